>>> src/cba_pkg.sv
`default_nettype none

package cba_pkg;

    // Field widths of the channels
    localparam int REQ_TYPE_W = 1;
    localparam int OWNER_ID_W = 16;
    localparam int LENGTH_W   = 11;
    localparam int START_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;

    // Default sizing
    localparam int CELLS_DEF      = 1024;
    localparam int OWNER_BITS_DEF = 16;

    // Request types
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    // Placement policies; the unused code falls back to first fit
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Datapath operation for the current cycle
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_INIT,
        OP_SCAN,
        OP_PURGE,
        OP_FILL
    } t_dp_op;

    typedef struct packed {
        t_dp_op                op;
        logic                  load;
        logic                  seed;
        logic                  emit;
        logic                  use_start;
        logic [STATUS_W-1:0]   code;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic scan_last;
        logic found;
        logic fill_last;
        logic owner_zero;
        logic len_bad;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> src/cba_if.sv
`default_nettype none

interface cba_req_if;
    logic                              valid;
    logic                              ready;
    logic [cba_pkg::REQ_TYPE_W-1:0]    req_type;
    logic [cba_pkg::OWNER_ID_W-1:0]    owner_id;
    logic [cba_pkg::LENGTH_W-1:0]      length;

    modport source (output valid, output req_type, output owner_id, output length,
                    input ready);
    modport sink   (input valid, input req_type, input owner_id, input length,
                    output ready);
endinterface

interface cba_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cba_pkg::START_W-1:0]       start_index;
    logic [cba_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output start_index, output status, input ready);
    modport sink   (input valid, input start_index, input status, output ready);
endinterface

interface cba_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cba_pkg::MODE_W-1:0]        fit_mode;

    modport source (output valid, output fit_mode, input ready);
    modport sink   (input valid, input fit_mode, output ready);
endinterface

`default_nettype wire

>>> src/cba_ram.sv
`default_nettype none

module cba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/cba_datapath.sv
`default_nettype none

module cba_datapath #(
    parameter int CELLS      = cba_pkg::CELLS_DEF,
    parameter int OWNER_BITS = cba_pkg::OWNER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cba_pkg::t_dp_cmd                i_cmd,
    output cba_pkg::t_dp_sts                     o_sts,
    input  wire logic                            i_cfg_we,
    input  wire logic [cba_pkg::MODE_W-1:0]      i_cfg_fit_mode,
    input  wire logic [cba_pkg::OWNER_ID_W-1:0]  i_owner_id,
    input  wire logic [cba_pkg::LENGTH_W-1:0]    i_length,
    output logic      [cba_pkg::START_W-1:0]     o_start_index,
    output logic      [cba_pkg::STATUS_W-1:0]    o_status
);

    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(CELLS + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(CELLS);
    localparam logic [CW-1:0] CNT_LAST = CW'(CELLS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);

    logic [cba_pkg::MODE_W-1:0] r_fit_mode;
    logic [CW-1:0]              r_cnt;
    logic                       r_dv;
    logic                       r_found;
    logic [AW-1:0]              r_da;
    logic [OWNER_BITS-1:0]      r_owner;
    logic [CW-1:0]              r_need;
    logic [CW-1:0]              r_run_len;
    logic [AW-1:0]              r_run_start;
    logic [AW-1:0]              r_best_start;
    logic [CW-1:0]              r_best_len;
    logic [CW-1:0]              r_left;
    logic [cba_pkg::START_W-1:0]  r_start_index;
    logic [cba_pkg::STATUS_W-1:0] r_status;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [OWNER_BITS-1:0] ram_wdata;
    logic [OWNER_BITS-1:0] ram_rdata;

    logic [OWNER_BITS-1:0] owner_in;
    logic                  issue;
    logic                  cell_free;
    logic                  at_end;
    logic [CW-1:0]         cand_len;
    logic [AW-1:0]         cand_start;
    logic                  cand_end;
    logic                  better;
    logic                  take;

    cba_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign owner_in = OWNER_BITS'(i_owner_id);
    assign issue    = ((i_cmd.op == cba_pkg::OP_SCAN) || (i_cmd.op == cba_pkg::OP_PURGE))
                      && (r_cnt != CNT_END);

    // Store write port: sweep, purge of matching cells, or run fill
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = '0;
        unique case (i_cmd.op)
            cba_pkg::OP_INIT: begin
                ram_we = 1'b1;
            end
            cba_pkg::OP_PURGE: begin
                ram_we    = r_dv && (ram_rdata == r_owner);
                ram_waddr = r_da;
            end
            cba_pkg::OP_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_owner;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Free-run tracking: a run closes on an owned cell or at the last cell
    always_comb begin
        cell_free  = (ram_rdata == '0);
        at_end     = (r_da == ADDR_LAST);
        cand_len   = cell_free ? (r_run_len + CW'(1)) : r_run_len;
        cand_start = (cell_free && (r_run_len == '0)) ? r_da : r_run_start;
        cand_end   = cell_free ? at_end : (r_run_len != '0);
        case (r_fit_mode)
            cba_pkg::FIT_BEST:  better = !r_found || (cand_len < r_best_len);
            cba_pkg::FIT_WORST: better = !r_found || (cand_len > r_best_len);
            default:            better = !r_found;
        endcase
        take = (i_cmd.op == cba_pkg::OP_SCAN) && r_dv && cand_end
               && (cand_len >= r_need) && better;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= cba_pkg::FIT_FIRST;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fit_mode <= i_cfg_fit_mode;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.seed) begin
                r_cnt <= CW'(r_best_start);
            end else if (issue || (i_cmd.op == cba_pkg::OP_INIT)
                         || (i_cmd.op == cba_pkg::OP_FILL)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_dv <= issue;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_da <= r_cnt[AW-1:0];
        if (i_cmd.load) begin
            r_owner   <= owner_in;
            r_need    <= CW'(i_length);
            r_run_len <= '0;
        end else if ((i_cmd.op == cba_pkg::OP_SCAN) && r_dv) begin
            r_run_len <= cell_free ? cand_len : '0;
            if (cell_free && (r_run_len == '0)) begin
                r_run_start <= r_da;
            end
        end
        if (take) begin
            r_best_start <= cand_start;
            r_best_len   <= cand_len;
        end
        if (i_cmd.seed) begin
            r_left <= r_need;
        end else if (i_cmd.op == cba_pkg::OP_FILL) begin
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.emit) begin
            r_start_index <= i_cmd.use_start ? cba_pkg::START_W'(r_best_start) : '0;
            r_status      <= i_cmd.code;
        end
    end

    assign o_sts.cnt_last   = (r_cnt == CNT_LAST);
    assign o_sts.scan_last  = r_dv && at_end;
    assign o_sts.found      = r_found;
    assign o_sts.fill_last  = (r_left == CW'(1));
    assign o_sts.owner_zero = (owner_in == '0);
    assign o_sts.len_bad    = (i_length == '0) || (32'(i_length) > 32'(CELLS));

    assign o_start_index = r_start_index;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_fill_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == cba_pkg::OP_FILL) |-> (r_left != '0))
        else $error("fill running with no cells left");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == cba_pkg::OP_FILL) |-> (r_cnt < CNT_END))
        else $error("fill address beyond the store");
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best_len >= r_need))
        else $error("chosen run shorter than the request");
`endif

endmodule

`default_nettype wire

>>> src/cba_ctrl.sv
`default_nettype none

module cba_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [cba_pkg::REQ_TYPE_W-1:0]     i_req_type,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    input  wire cba_pkg::t_dp_sts                   i_sts,
    output cba_pkg::t_dp_cmd                        o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_FILL,
        S_PURGE,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_out_valid, n_out_valid;
    logic [cba_pkg::STATUS_W-1:0] r_code, n_code;
    logic                        r_use_start, n_use_start;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_code         = r_code;
        n_use_start    = r_use_start;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.op       = cba_pkg::OP_IDLE;
        o_cmd.code     = r_code;
        o_cmd.use_start = r_use_start;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = cba_pkg::OP_INIT;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load  = 1'b1;
                    n_code      = cba_pkg::STATUS_OK;
                    n_use_start = 1'b0;
                    if (i_req_type == cba_pkg::REQ_CLEAR) begin
                        n_state = i_sts.owner_zero ? S_DONE : S_PURGE;
                    end else if (i_sts.owner_zero || i_sts.len_bad) begin
                        n_code  = cba_pkg::STATUS_BAD;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.op = cba_pkg::OP_SCAN;
                if (i_sts.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.found) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_FILL;
                end else begin
                    n_code  = cba_pkg::STATUS_NOFIT;
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                o_cmd.op = cba_pkg::OP_FILL;
                if (i_sts.fill_last) begin
                    n_use_start = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_PURGE: begin
                o_cmd.op = cba_pkg::OP_PURGE;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_code      <= cba_pkg::STATUS_OK;
            r_use_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
            r_use_start <= n_use_start;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while one is in flight");
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");
`endif

endmodule

`default_nettype wire

>>> src/contiguous_block_allocator_top.sv
`default_nettype none

// Contiguous block allocator.
// A store of CELLS owner tags (0 = free) lives in one RAM. Requests come in on
// i_req: an allocate (req_type 0) marks a run of length free cells with owner_id,
// placed by the fit_mode register (first, best or worst fit, earliest on ties);
// a clear (req_type 1) frees every cell held by owner_id. Each request gives one
// transfer on o_rsp with start_index and status (ok, no fit, bad request).
// i_cfg writes fit_mode; it is always ready and is meant to be written while idle.
// Flow: one request at a time. An allocate scans the store through the RAM read
// port, picks the run, fills it and loads the result (when nothing fits, it loads
// the result straight after the pick). A clear reads and writes back the store in
// one pass. A rejected request, or a clear of owner 0, goes from idle straight to
// the result load. The next request is taken from the cycle after the previous
// result is loaded.
// Reset: after i_rst_n releases, a clearing pass writes every cell free, during
// which i_req.ready stays low.
// Stall: the result sits in an output register until o_rsp.ready; the next
// request may be taken and processed meanwhile, and its result waits until that
// register has been drained.

module contiguous_block_allocator_top #(
    parameter int CELLS      = cba_pkg::CELLS_DEF,
    parameter int OWNER_BITS = cba_pkg::OWNER_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cba_req_if.sink    i_req,
    cba_rsp_if.source  o_rsp,
    cba_cfg_if.sink    i_cfg
);

    cba_pkg::t_dp_cmd dp_cmd;
    cba_pkg::t_dp_sts dp_sts;

    // Configuration is taken every cycle
    assign i_cfg.ready = 1'b1;

    cba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_req_type  (i_req.req_type),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    cba_datapath #(
        .CELLS      (CELLS),
        .OWNER_BITS (OWNER_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_fit_mode (i_cfg.fit_mode),
        .i_owner_id     (i_req.owner_id),
        .i_length       (i_req.length),
        .o_start_index  (o_rsp.start_index),
        .o_status       (o_rsp.status)
    );

endmodule

`default_nettype wire
